>>> src/qad_pkg.sv
// Shared types and constants for the quad autosprite deform unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package qad_pkg;

  // Field and intermediate widths.
  localparam int POS_W       = 32;  // Q16.16 positions
  localparam int DIR_W       = 16;  // Q2.14 direction components
  localparam int CFG_IDX_W   = 3;   // configuration register index
  localparam int MID_SUM_W   = 34;  // sum of four positions
  localparam int DIFF_W      = 33;  // vertex0 minus midpoint
  localparam int SQ_W        = 64;  // square of one magnitude
  localparam int ACC_W       = 66;  // sum of three squares
  localparam int ROOT_W      = 33;  // integer square root of ACC_W bits
  localparam int REM_W       = 34;  // square root remainder
  localparam int RAD_W       = 33;  // radius after the 0.707 scale
  localparam int SCALE_W     = 16;  // width of the radius scale constant
  localparam int SCALE_PROD_W = ROOT_W + SCALE_W;
  localparam int DIR_PROD_W  = DIR_W + RAD_W + 1;
  localparam int DIR_FRAC    = 14;  // fraction bits of the directions
  localparam int LU_W        = DIR_PROD_W - DIR_FRAC;  // scaled left/up offset
  localparam int CORNER_W    = LU_W + 2;               // mid plus two offsets
  localparam int CNT_W       = 6;   // sequence counter

  // 0.707 in Q0.16.
  localparam logic [SCALE_W-1:0] RAD_SCALE = 16'd46334;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UP_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Z   = 3'd5;

  // Direction reset values: left along x, up along z.
  localparam logic signed [DIR_W-1:0] DIR_ONE = 16'sd16384;

  // Slot of the vertex that completes a quad.
  localparam logic [1:0] SLOT_FOURTH = 2'd3;

  // Corner codes in emit order.
  localparam logic [1:0] CORNER_FIRST  = 2'd0;
  localparam logic [1:0] CORNER_SECOND = 2'd1;
  localparam logic [1:0] CORNER_THIRD  = 2'd2;
  localparam logic [1:0] CORNER_LAST   = 2'd3;

  // Last count of each multi-cycle step.
  localparam logic [CNT_W-1:0] SQ_LAST   = 6'd3;
  localparam logic [CNT_W-1:0] ROOT_LAST = 6'd32;
  localparam logic [CNT_W-1:0] DIR_LAST  = 6'd5;
  localparam logic [CNT_W-1:0] EMIT_LAST = 6'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       hold_en;
    logic [1:0] hold_slot;
    logic       mid_en;
    logic       diff_en;
    logic       sq_en;
    logic [1:0] sq_sel;
    logic       acc_clr;
    logic       acc_add;
    logic       root_step;
    logic       scale_en;
    logic       dir_en;
    logic [2:0] dir_sel;
    logic       out_load;
    logic [1:0] corner;
  } qad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } qad_stat_t;

endpackage

>>> src/qad_if.sv
// Stream interfaces of the quad autosprite deform unit: vertex in, corner out.
// Depends on qad_pkg for the field widths.
interface qad_vtx_if
  import qad_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface qad_crn_if
  import qad_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;
  logic signed [POS_W-1:0] out_z;
  logic                    tex_u;
  logic                    tex_v;
  logic                    last_corner;

  modport source (output valid, output out_x, output out_y, output out_z, output tex_u,
                  output tex_v, output last_corner, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input tex_u,
                  input tex_v, input last_corner, output ready);
endinterface

>>> src/qad_ctrl.sv
// Controller of the quad autosprite deform unit: sequences vertex capture,
// the square sum, the bit-serial square root, scaling and corner emission.
// Depends on qad_pkg.
module qad_ctrl
  import qad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  qad_stat_t stat,
  output qad_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIFF  = 7'b0000010,
    ST_SQ    = 7'b0000100,
    ST_ROOT  = 7'b0001000,
    ST_SCALE = 7'b0010000,
    ST_DIR   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } qad_state_t;

  qad_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       slot_r, slot_nxt;

  // Next state, counters and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + CNT_W'(1);
    slot_nxt  = slot_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          if (slot_r == SLOT_FOURTH) begin
            // The fourth vertex closes the quad and starts the computation.
            cmd.mid_en = 1'b1;
            slot_nxt   = '0;
            state_nxt  = ST_DIFF;
          end else begin
            cmd.hold_en   = 1'b1;
            cmd.hold_slot = slot_r;
            slot_nxt      = slot_r + 2'd1;
          end
        end
      end
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_SQ;
      end
      ST_SQ: begin
        // One square per cycle; the accumulator adds each product from prod_r, the multiplier's output register.
        cmd.sq_en   = (cnt_r != SQ_LAST);
        cmd.sq_sel  = cnt_r[1:0];
        cmd.acc_clr = (cnt_r == '0);
        cmd.acc_add = (cnt_r != '0);
        if (cnt_r == SQ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_r == ROOT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale_en = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIR;
      end
      ST_DIR: begin
        cmd.dir_en  = 1'b1;
        cmd.dir_sel = cnt_r[2:0];
        if (cnt_r == DIR_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cnt_nxt = cnt_r;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.corner   = cnt_r[1:0];
          cnt_nxt      = cnt_r + CNT_W'(1);
          if (cnt_r == EMIT_LAST) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      slot_r  <= slot_nxt;
    end
  end

endmodule

>>> src/qad_dp.sv
// Datapath of the quad autosprite deform unit: held vertices, midpoint,
// square sum, square root, direction scaling and the corner output register.
// Depends on qad_pkg; driven by qad_ctrl commands.
module qad_dp
  import qad_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  qad_cmd_t                cmd,
  output qad_stat_t               stat,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_idx,
  input  logic [DIR_W-1:0]        cfg_wdata,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] out_x,
  output logic signed [POS_W-1:0] out_y,
  output logic signed [POS_W-1:0] out_z,
  output logic                    tex_u,
  output logic                    tex_v,
  output logic                    last_corner
);

  // Saturate a corner sum to the signed position range.
  function automatic logic [POS_W-1:0] sat_pos(input logic [CORNER_W-1:0] v);
    logic [CORNER_W-POS_W:0] top;
    top = v[CORNER_W-1:POS_W-1];
    if ((&top) || !(|top)) begin
      sat_pos = v[POS_W-1:0];
    end else if (v[CORNER_W-1]) begin
      sat_pos = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      sat_pos = {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

  logic signed [DIR_W-1:0]      dir_r [6];
  logic signed [POS_W-1:0]      held_r [3][3];
  logic signed [POS_W-1:0]      mid_r [3];
  logic [POS_W-1:0]             absd_r [3];
  logic [SQ_W-1:0]              prod_r;
  logic [ACC_W-1:0]             acc_r;
  logic [REM_W-1:0]             rem_r;
  logic [ROOT_W-1:0]            root_r;
  logic [RAD_W-1:0]             rad_r;
  logic signed [LU_W-1:0]       lu_r [6];
  logic                         out_valid_r;
  logic signed [POS_W-1:0]      out_pos_r [3];
  logic                         tex_u_r, tex_v_r, last_r;

  logic signed [POS_W-1:0]      pos [3];
  logic signed [MID_SUM_W-1:0]  mid_sum [3];
  logic signed [DIFF_W-1:0]     diff [3];
  logic [POS_W-1:0]             absd_nxt [3];
  logic [SQ_W-1:0]              sq_prod;
  logic [REM_W+1:0]             rt_cand, rt_trial, rt_sub;
  logic                         rt_take;
  logic [SCALE_PROD_W-1:0]      scale_prod;
  logic signed [DIR_PROD_W-1:0] dir_prod;
  logic                         l_plus, u_plus;
  logic signed [CORNER_W-1:0]   corner_sum [3];
  logic signed [CORNER_W-1:0]   l_ext [3];
  logic signed [CORNER_W-1:0]   u_ext [3];

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  // Midpoint sum and the magnitude of vertex0 minus the midpoint, per axis.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mid_sum[a]  = MID_SUM_W'(held_r[a][0]) + MID_SUM_W'(held_r[a][1])
                  + MID_SUM_W'(held_r[a][2]) + MID_SUM_W'(pos[a]);
      diff[a]     = DIFF_W'(held_r[a][0]) - DIFF_W'(mid_r[a]);
      absd_nxt[a] = diff[a][DIFF_W-1] ? POS_W'(-diff[a]) : POS_W'(diff[a]);
    end
  end

  // Shared squaring multiplier.
  assign sq_prod = SQ_W'(absd_r[cmd.sq_sel]) * SQ_W'(absd_r[cmd.sq_sel]);

  // One bit of the restoring square root; radicand bits come from the top of acc_r.
  assign rt_cand  = {rem_r, acc_r[ACC_W-1:ACC_W-2]};
  assign rt_trial = {1'b0, root_r, 2'b01};
  assign rt_take  = (rt_cand >= rt_trial);
  assign rt_sub   = rt_cand - rt_trial;

  // Radius scale and the shared direction multiplier.
  assign scale_prod = SCALE_PROD_W'(root_r) * SCALE_PROD_W'(RAD_SCALE);
  assign dir_prod   = $signed(dir_r[cmd.dir_sel]) * $signed({1'b0, rad_r});

  // Corner sums: the left offset is added on corners 0 and 3, up on corners 0 and 1.
  assign l_plus = (cmd.corner == CORNER_FIRST) || (cmd.corner == CORNER_LAST);
  assign u_plus = (cmd.corner == CORNER_FIRST) || (cmd.corner == CORNER_SECOND);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      l_ext[a]      = CORNER_W'(lu_r[a]);
      u_ext[a]      = CORNER_W'(lu_r[a+3]);
      corner_sum[a] = CORNER_W'(mid_r[a]) + (l_plus ? l_ext[a] : -l_ext[a])
                    + (u_plus ? u_ext[a] : -u_ext[a]);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r[REG_LEFT_X] <= DIR_ONE;
      dir_r[REG_LEFT_Y] <= '0;
      dir_r[REG_LEFT_Z] <= '0;
      dir_r[REG_UP_X]   <= '0;
      dir_r[REG_UP_Y]   <= '0;
      dir_r[REG_UP_Z]   <= DIR_ONE;
    end else if (cfg_we && (cfg_idx <= REG_UP_Z)) begin
      dir_r[cfg_idx] <= cfg_wdata;
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.hold_en) begin
      for (int a = 0; a < 3; a++) begin
        held_r[a][cmd.hold_slot] <= pos[a];
      end
    end
    if (cmd.mid_en) begin
      for (int a = 0; a < 3; a++) begin
        mid_r[a] <= mid_sum[a][MID_SUM_W-1:2];
      end
    end
    if (cmd.diff_en) begin
      for (int a = 0; a < 3; a++) begin
        absd_r[a] <= absd_nxt[a];
      end
    end
    if (cmd.sq_en) begin
      prod_r <= sq_prod;
    end
    if (cmd.acc_clr) begin
      acc_r  <= '0;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end else if (cmd.root_step) begin
      acc_r  <= {acc_r[ACC_W-3:0], 2'b00};
      rem_r  <= rt_take ? rt_sub[REM_W-1:0] : rt_cand[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], rt_take};
    end
    if (cmd.scale_en) begin
      rad_r <= scale_prod[SCALE_PROD_W-1:SCALE_W];
    end
    if (cmd.dir_en) begin
      lu_r[cmd.dir_sel] <= dir_prod[DIR_PROD_W-1:DIR_FRAC];
    end
  end

  // Output register: valid is control, the corner word is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int a = 0; a < 3; a++) begin
        out_pos_r[a] <= sat_pos(corner_sum[a]);
      end
      tex_u_r <= (cmd.corner == CORNER_SECOND) || (cmd.corner == CORNER_THIRD);
      tex_v_r <= (cmd.corner == CORNER_THIRD) || (cmd.corner == CORNER_LAST);
      last_r  <= (cmd.corner == CORNER_LAST);
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_x         = out_pos_r[0];
  assign out_y         = out_pos_r[1];
  assign out_z         = out_pos_r[2];
  assign tex_u         = tex_u_r;
  assign tex_v         = tex_v_r;
  assign last_corner   = last_r;

endmodule

>>> src/quad_autosprite_deform_unit.sv
// Quad autosprite deform unit, top level.
// Vertex words (pos_x/y/z, signed Q16.16) enter on in_vtx; corner words
// (out_x/y/z saturated Q16.16, tex_u, tex_v, last_corner) leave on out_crn.
// Both channels move a word at a clock edge where valid and ready are high.
// The first three vertices of each quad are stored, one per cycle. The fourth
// starts the computation: midpoint, sum of squares (one multiplier), a
// bit-serial square root (one root bit per cycle), radius scale and six
// direction products on one multiplier. The first corner is loaded once the
// direction products are done, and the others follow one per cycle when the
// receiver does not stall. The square root is the longest step.
// in_vtx.ready is high only while no quad is in work; the last corner may still
// wait in the output register while the next quad's vertices are taken.
// If the receiver stalls, the corner word holds and the sequence waits.
// The user must write directions through cfg_we/cfg_idx/cfg_wdata only while
// idle; the block does not enforce it. Indexes above five are ignored.
// Synchronous reset clears the quad slot, the sequencer and the output valid,
// and loads left = +x and up = +z.
module quad_autosprite_deform_unit
  import qad_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  qad_vtx_if.sink              in_vtx,
  qad_crn_if.source            out_crn,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DIR_W-1:0]     cfg_wdata
);

  qad_cmd_t  cmd;
  qad_stat_t stat;

  // Sequencer.
  qad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_vtx.valid),
    .in_ready (in_vtx.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and output register.
  qad_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .pos_x       (in_vtx.pos_x),
    .pos_y       (in_vtx.pos_y),
    .pos_z       (in_vtx.pos_z),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_crn.valid),
    .out_ready   (out_crn.ready),
    .out_x       (out_crn.out_x),
    .out_y       (out_crn.out_y),
    .out_z       (out_crn.out_z),
    .tex_u       (out_crn.tex_u),
    .tex_v       (out_crn.tex_v),
    .last_corner (out_crn.last_corner)
  );

  // A corner load never overwrites a word the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_crn.valid || out_crn.ready))
    else $error("corner word overwritten before it was taken");

  // Once a quad closes, input is blocked on the next cycle.
  a_quad_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mid_en |=> !in_vtx.ready)
    else $error("input ready while a quad is in work");

  // While vertices are taken, only the last corner of a quad may still wait.
  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vtx.ready && out_crn.valid) |-> out_crn.last_corner)
    else $error("input taken while corners of a quad are pending");

  // Vertex hold, midpoint, root step, direction and corner load never overlap.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.hold_en, cmd.mid_en, cmd.root_step, cmd.dir_en, cmd.out_load}) <= 1)
    else $error("conflicting datapath commands");

endmodule

>>> tb/sv/quad_autosprite_deform_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for quad_autosprite_deform_unit: quads of vertex words in,
// billboard corner words out, each corner checked against a local corner predictor.
// Depends on qad_pkg and the qad_vtx_if / qad_crn_if interfaces.
module quad_autosprite_deform_unit_tb;
  import qad_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 64;
  localparam int IDLE_LIMIT      = 2000;
  localparam int QUADS_PER_PHASE = 4;

  // Indexes past the last direction register; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [POS_W-1:0] POS_ONE = 32'sd65536;
  localparam logic [DIR_W-1:0]        DIR_MAX = 16'h7FFF;
  localparam logic [DIR_W-1:0]        DIR_MIN = 16'h8000;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic                    tex_u;
    logic                    tex_v;
    logic                    last_corner;
  } corner_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [DIR_W-1:0]     cfg_wdata = '0;
  logic                 vtx_valid_q = 1'b0;
  vertex_t              vtx_word_q  = '0;
  logic                 crn_ready_q = 1'b0;

  qad_vtx_if vtx_bus ();
  qad_crn_if crn_bus ();

  assign vtx_bus.valid = vtx_valid_q;
  assign vtx_bus.pos_x = vtx_word_q.x;
  assign vtx_bus.pos_y = vtx_word_q.y;
  assign vtx_bus.pos_z = vtx_word_q.z;
  assign crn_bus.ready = crn_ready_q;

  quad_autosprite_deform_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vtx    (vtx_bus),
    .out_crn   (crn_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Pending vertex words, predicted corner words, and the predictor's own state.
  vertex_t                 vertex_queue[$];
  corner_t                 corner_queue[$];
  longint                  held_pos[3][3];
  logic [1:0]              quad_slot;
  logic signed [DIR_W-1:0] left_dir[3];
  logic signed [DIR_W-1:0] up_dir[3];

  bit vtx_fire    = 1'b0;
  bit crn_fire    = 1'b0;
  bit vtx_hold    = 1'b0;
  bit no_idle     = 1'b0;
  int vtx_gap     = 0;
  int crn_stall   = 0;
  int idle_cycles = 0;
  int error_count = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic signed [POS_W-1:0] saturate_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v[POS_W-1:0];
  endfunction

  // Register write as the block sees it; unknown indexes leave everything alone.
  function automatic void apply_dir_write(logic [CFG_IDX_W-1:0] idx, logic [DIR_W-1:0] data);
    unique case (idx)
      REG_LEFT_X: left_dir[0] = data;
      REG_LEFT_Y: left_dir[1] = data;
      REG_LEFT_Z: left_dir[2] = data;
      REG_UP_X:   up_dir[0]   = data;
      REG_UP_Y:   up_dir[1]   = data;
      REG_UP_Z:   up_dir[2]   = data;
      default: ;
    endcase
  endfunction

  // Append one vertex word to the driver's queue.
  task automatic queue_vertex(input vertex_t v);
    vertex_queue.insert(vertex_queue.size(), v);
  endtask

  // Hold the first three vertices; on the fourth, predict the four billboard corners.
  task automatic predict_corners(input vertex_t v);
    longint            pos[3];
    longint            mid[3];
    longint            lofs[3];
    longint            uofs[3];
    longint            cval[3];
    longint            dev;
    longint            rad;
    longint unsigned   mag;
    logic [67:0]       sum_sq;
    logic [67:0]       trial_sq;
    logic [33:0]       root;
    logic [33:0]       trial;
    logic [1:0]        corner_id;
    bit                left_plus;
    bit                up_plus;
    corner_t           cw;
    pos[0] = v.x;
    pos[1] = v.y;
    pos[2] = v.z;
    if (quad_slot != SLOT_FOURTH) begin
      for (int a = 0; a < 3; a++) held_pos[quad_slot][a] = pos[a];
      quad_slot = quad_slot + 2'd1;
    end else begin
      quad_slot = '0;
      sum_sq = '0;
      // Midpoint floors toward minus infinity; squared distance from vertex 0 is exact.
      for (int a = 0; a < 3; a++) begin
        mid[a] = (held_pos[0][a] + held_pos[1][a] + held_pos[2][a] + pos[a]) >>> 2;
        dev = held_pos[0][a] - mid[a];
        mag = (dev < 0) ? -dev : dev;
        sum_sq = sum_sq + mag * mag;
      end
      // Exact integer square root, one bit at a time from the top.
      root = '0;
      for (int b = 33; b >= 0; b--) begin
        trial = root | (34'd1 << b);
        trial_sq = trial * trial;
        if (trial_sq <= sum_sq) root = trial;
      end
      rad = (longint'(root) * longint'(RAD_SCALE)) >>> 16;
      for (int a = 0; a < 3; a++) begin
        lofs[a] = (longint'(left_dir[a]) * rad) >>> DIR_FRAC;
        uofs[a] = (longint'(up_dir[a]) * rad) >>> DIR_FRAC;
      end
      // Corners go around the quad: +L+U, -L+U, -L-U, +L-U.
      for (int k = 0; k < 4; k++) begin
        corner_id = 2'(k);
        left_plus = (corner_id == CORNER_FIRST) || (corner_id == CORNER_LAST);
        up_plus   = (corner_id == CORNER_FIRST) || (corner_id == CORNER_SECOND);
        for (int a = 0; a < 3; a++)
          cval[a] = mid[a] + (left_plus ? lofs[a] : -lofs[a]) + (up_plus ? uofs[a] : -uofs[a]);
        cw.x = saturate_pos(cval[0]);
        cw.y = saturate_pos(cval[1]);
        cw.z = saturate_pos(cval[2]);
        cw.tex_u = (corner_id == CORNER_SECOND) || (corner_id == CORNER_THIRD);
        cw.tex_v = (corner_id == CORNER_THIRD) || (corner_id == CORNER_LAST);
        cw.last_corner = (corner_id == CORNER_LAST);
        corner_queue.insert(corner_queue.size(), cw);
      end
    end
  endtask

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  task automatic check_corner();
    corner_t want;
    if (corner_queue.size() == 0) begin
      $error("corner word with no prediction waiting: x %0d y %0d z %0d",
             crn_bus.out_x, crn_bus.out_y, crn_bus.out_z);
      error_count++;
    end else begin
      want = corner_queue.pop_front();
      check_field("out_x", want.x, crn_bus.out_x);
      check_field("out_y", want.y, crn_bus.out_y);
      check_field("out_z", want.z, crn_bus.out_z);
      check_field("tex_u", want.tex_u, crn_bus.tex_u);
      check_field("tex_v", want.tex_v, crn_bus.tex_v);
      check_field("last_corner", want.last_corner, crn_bus.last_corner);
    end
  endtask

  // Monitor: sample both handshakes at the rising edge, check first, then predict.
  always @(posedge clk) begin
    vtx_fire = rst_n && vtx_bus.valid && vtx_bus.ready;
    crn_fire = rst_n && crn_bus.valid && crn_bus.ready;
    if (crn_fire) check_corner();
    if (vtx_fire) predict_corners(vtx_word_q);
    idle_cycles = (vtx_fire || crn_fire || !rst_n) ? 0 : idle_cycles + 1;
  end

  // Driver: present queued vertex words, with a random gap after each accepted word.
  always @(negedge clk) begin
    if (rst_n) begin
      if (vtx_hold && vtx_fire) begin
        vtx_hold = 1'b0;
        vtx_gap = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (!vtx_hold) begin
        if (vtx_gap > 0) begin
          vtx_gap--;
        end else if (vertex_queue.size() > 0) begin
          vtx_word_q <= vertex_queue.pop_front();
          vtx_hold = 1'b1;
        end
      end
      vtx_valid_q <= vtx_hold;
    end
  end

  // Receiver: after each accepted corner word, stall ready for a random count.
  always @(negedge clk) begin
    if (rst_n) begin
      if (crn_fire) crn_stall = no_idle ? 0 : $urandom_range(0, 3);
      if (crn_stall > 0) begin
        crn_stall--;
        crn_ready_q <= 1'b0;
      end else begin
        crn_ready_q <= 1'b1;
      end
    end
  end

  // A run that stops moving words ends here.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(negedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // Any 32-bit value, arithmetically shifted so that small magnitudes are common.
  function automatic logic signed [POS_W-1:0] spread_word();
    logic signed [POS_W-1:0] w;
    w = $urandom;
    return w >>> $urandom_range(0, 31);
  endfunction

  function automatic logic signed [POS_W-1:0] boundary_word();
    unique case ($urandom_range(0, 4))
      0: return POS_MIN;
      1: return POS_MAX;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_quad(input vertex_t v0, input vertex_t v1, input vertex_t v2,
                          input vertex_t v3);
    queue_vertex(v0);
    queue_vertex(v1);
    queue_vertex(v2);
    queue_vertex(v3);
  endtask

  // Mostly compact quads around a random center, some fully random, some at the rails.
  task automatic add_random_quad();
    int      kind;
    int      shrink;
    vertex_t center;
    vertex_t v;
    kind = $urandom_range(0, 9);
    shrink = $urandom_range(0, 20);
    center = '{spread_word(), spread_word(), spread_word()};
    for (int i = 0; i < 4; i++) begin
      if (kind < 6)
        v = '{center.x + (spread_word() >>> shrink), center.y + (spread_word() >>> shrink),
              center.z + (spread_word() >>> shrink)};
      else if (kind < 8)
        v = '{$urandom, $urandom, $urandom};
      else
        v = '{boundary_word(), boundary_word(), boundary_word()};
      queue_vertex(v);
    end
  endtask

  task automatic write_dir(input logic [CFG_IDX_W-1:0] idx, input logic [DIR_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    apply_dir_write(idx, data);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_dirs(input logic [DIR_W-1:0] lx, input logic [DIR_W-1:0] ly,
                          input logic [DIR_W-1:0] lz, input logic [DIR_W-1:0] ux,
                          input logic [DIR_W-1:0] uy, input logic [DIR_W-1:0] uz);
    write_dir(REG_LEFT_X, lx);
    write_dir(REG_LEFT_Y, ly);
    write_dir(REG_LEFT_Z, lz);
    write_dir(REG_UP_X, ux);
    write_dir(REG_UP_Y, uy);
    write_dir(REG_UP_Z, uz);
  endtask

  // Random directions for all six registers.
  task automatic set_random_dirs();
    set_dirs(DIR_W'($urandom), DIR_W'($urandom), DIR_W'($urandom),
             DIR_W'($urandom), DIR_W'($urandom), DIR_W'($urandom));
  endtask

  // Wait until every queued vertex is taken and every predicted corner has come back.
  task automatic wait_drained();
    while (vertex_queue.size() > 0 || vtx_hold || corner_queue.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase();
    for (int q = 0; q < QUADS_PER_PHASE; q++) add_random_quad();
    wait_drained();
  endtask

  initial begin
    // Predictor state after reset: left along +x, up along +z, slot zero.
    left_dir  = '{DIR_ONE, 16'sd0, 16'sd0};
    up_dir    = '{16'sd0, 16'sd0, DIR_ONE};
    quad_slot = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed quads with the reset directions.
    add_quad('{32'sd0, 32'sd0, 32'sd0}, '{32'sd0, 32'sd0, 32'sd0},
             '{32'sd0, 32'sd0, 32'sd0}, '{32'sd0, 32'sd0, 32'sd0});
    add_quad('{-POS_ONE, 32'sd0, POS_ONE}, '{POS_ONE, 32'sd0, POS_ONE},
             '{POS_ONE, 32'sd0, -POS_ONE}, '{-POS_ONE, 32'sd0, -POS_ONE});
    // Largest spread both ways: corners run into saturation.
    add_quad('{POS_MAX, POS_MAX, POS_MAX}, '{POS_MIN, POS_MIN, POS_MIN},
             '{POS_MIN, POS_MIN, POS_MIN}, '{POS_MIN, POS_MIN, POS_MIN});
    add_quad('{POS_MIN, POS_MIN, POS_MIN}, '{POS_MAX, POS_MAX, POS_MAX},
             '{POS_MAX, POS_MAX, POS_MAX}, '{POS_MAX, POS_MAX, POS_MAX});
    // Negative sums that are not multiples of four: the midpoint floors downward.
    add_quad('{-32'sd1, -32'sd2, -32'sd3}, '{-32'sd1, 32'sd0, 32'sd0},
             '{32'sd0, 32'sd0, 32'sd0}, '{32'sd0, -32'sd1, -32'sd2});
    add_quad('{POS_MAX, POS_MIN, 32'sd0}, '{POS_MIN, POS_MAX, -32'sd1},
             '{32'sd0, -32'sd1, POS_MAX}, '{-32'sd1, 32'sd0, POS_MIN});
    wait_drained();

    // Random directions; writes to the spare indexes must change nothing.
    set_random_dirs();
    write_dir(REG_SPARE_LO, DIR_W'($urandom));
    write_dir(REG_SPARE_HI, DIR_W'($urandom));
    run_random_phase();

    // Most negative directions.
    set_dirs(DIR_MIN, DIR_MIN, DIR_MIN, DIR_MIN, DIR_MIN, DIR_MIN);
    run_random_phase();

    // Most positive directions, spare indexes written again.
    set_dirs(DIR_MAX, DIR_MAX, DIR_MAX, DIR_MAX, DIR_MAX, DIR_MAX);
    write_dir(REG_SPARE_HI, DIR_MIN);
    run_random_phase();

    // Random directions with both sides streaming at full rate, then with random gaps again.
    set_random_dirs();
    no_idle = 1'b1;
    run_random_phase();
    no_idle = 1'b0;
    run_random_phase();

    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
